[src/sipeg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sipeg_pkg
// Shared types, constants and round functions of the edge generator built on
// SipHash-2-4: the four-word hash state and the two half rounds.
// ============================================================================
package sipeg_pkg;

    // Field and port widths
    localparam int C_EDGE_BITS = 15;   // default graph size in bits
    localparam int C_IN_W      = 15;   // edge index width
    localparam int C_OUT_W     = 16;   // node width
    localparam int C_NONCE_W   = 16;   // nonce is 2e or 2e+1
    localparam int C_WORD_W    = 64;
    localparam int C_DATA_W    = 64;   // configuration data width
    localparam int C_ADDR_W    = 5;    // four 64-bit registers at 8-byte steps

    // Register indexes (paddr[4:3])
    localparam logic [1:0] C_REG_KEY0 = 2'd0;
    localparam logic [1:0] C_REG_KEY1 = 2'd1;
    localparam logic [1:0] C_REG_KEY2 = 2'd2;
    localparam logic [1:0] C_REG_KEY3 = 2'd3;

    // Round schedule: two compression rounds, four finalization rounds
    localparam int C_HALF_ROUNDS = 12;
    localparam int C_COMP_HALVES = 4;
    localparam logic [C_WORD_W-1:0] C_FINAL_XOR = 64'h0000_0000_0000_00ff;

    // SipHash state v0..v3
    typedef struct packed {
        logic [C_WORD_W-1:0] a;
        logic [C_WORD_W-1:0] b;
        logic [C_WORD_W-1:0] c;
        logic [C_WORD_W-1:0] d;
    } t_sip_state;

    // First half of a SipRound: rotations 13, 16 and 32
    function automatic t_sip_state half_a(input t_sip_state s);
        t_sip_state r;
        logic [C_WORD_W-1:0] sa;
        logic [C_WORD_W-1:0] sc;
        sa  = s.a + s.b;
        sc  = s.c + s.d;
        r.b = {s.b[50:0], s.b[63:51]} ^ sa;
        r.d = {s.d[47:0], s.d[63:48]} ^ sc;
        r.a = {sa[31:0], sa[63:32]};
        r.c = sc;
        return r;
    endfunction

    // Second half of a SipRound: rotations 17, 21 and 32
    function automatic t_sip_state half_b(input t_sip_state s);
        t_sip_state r;
        logic [C_WORD_W-1:0] sa;
        logic [C_WORD_W-1:0] sc;
        sc  = s.c + s.b;
        sa  = s.a + s.d;
        r.b = {s.b[46:0], s.b[63:47]} ^ sc;
        r.d = {s.d[42:0], s.d[63:43]} ^ sa;
        r.c = {sc[31:0], sc[63:32]};
        r.a = sa;
        return r;
    endfunction

endpackage
`default_nettype wire

[src/siphash_edge_generator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// siphash_edge_generator_unit
// Cuckoo-graph edge generator: hashes nonces 2e and 2e+1 with SipHash-2-4
// under a 256-bit key and returns the two masked, shifted endpoints.
// ============================================================================
//  channel   ports                                  direction  handshake
//  edge in   start, busy, i_edge_index              in         start & !busy
//  nodes     o_valid, o_even_node, o_odd_node       out        o_valid strobe
//  config    psel, penable, pwrite, paddr, pwdata,  in/out     APB, 64-bit
//            prdata, pready
//
//  One edge word is taken every cycle; busy is never raised.
//  The pipeline is a load stage, twelve half-round stages (two
//  64-bit adds each) and an output register; both nonces run in two
//  parallel lanes.
//  Reset is synchronous, active low, and clears all valid bits and keys.
//  The receiver cannot stall, so the pipeline never holds.
// ============================================================================
module siphash_edge_generator_unit #(
    parameter int EDGE_BITS = sipeg_pkg::C_EDGE_BITS
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // edge input
    input  wire                                  start,
    output logic                                 busy,
    input  wire [sipeg_pkg::C_IN_W-1:0]          i_edge_index,
    // node output
    output logic                                 o_valid,
    output logic [sipeg_pkg::C_OUT_W-1:0]        o_even_node,
    output logic [sipeg_pkg::C_OUT_W-1:0]        o_odd_node,
    // configuration
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [sipeg_pkg::C_ADDR_W-1:0]        paddr,
    input  wire [sipeg_pkg::C_DATA_W-1:0]        pwdata,
    output logic [sipeg_pkg::C_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int L_IW = sipeg_pkg::C_IN_W;
    localparam int L_NW = sipeg_pkg::C_NONCE_W;
    localparam logic [L_IW-1:0] L_MASK = L_IW'((64'd1 << EDGE_BITS) - 64'd1);

    logic [sipeg_pkg::C_WORD_W-1:0] r_key0;
    logic [sipeg_pkg::C_WORD_W-1:0] r_key1;
    logic [sipeg_pkg::C_WORD_W-1:0] r_key2;
    logic [sipeg_pkg::C_WORD_W-1:0] r_key3;
    sipeg_pkg::t_sip_state          w_key;
    logic [1:0]                     w_reg_idx;
    logic                           w_cfg_wr;
    logic                           w_accept;
    logic                           w_even_vld;
    logic                           w_odd_vld;
    logic [sipeg_pkg::C_WORD_W-1:0] w_even_hash;
    logic [sipeg_pkg::C_WORD_W-1:0] w_odd_hash;
    logic                           r_out_vld;
    logic [sipeg_pkg::C_OUT_W-1:0]  r_even;
    logic [sipeg_pkg::C_OUT_W-1:0]  r_odd;

    // Configuration port: always ready, write on the access cycle
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:3];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                sipeg_pkg::C_REG_KEY0: r_key0 <= pwdata;
                sipeg_pkg::C_REG_KEY1: r_key1 <= pwdata;
                sipeg_pkg::C_REG_KEY2: r_key2 <= pwdata;
                sipeg_pkg::C_REG_KEY3: r_key3 <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_reg_idx)
            sipeg_pkg::C_REG_KEY0: prdata = r_key0;
            sipeg_pkg::C_REG_KEY1: prdata = r_key1;
            sipeg_pkg::C_REG_KEY2: prdata = r_key2;
            sipeg_pkg::C_REG_KEY3: prdata = r_key3;
            default:               prdata = '0;
        endcase
    end

    assign w_key    = '{a: r_key0, b: r_key1, c: r_key2, d: r_key3};
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Two lanes: nonce 2e and nonce 2e+1
    sipeg_lane u_even (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_nonce ({i_edge_index, 1'b0}),
        .i_key   (w_key),
        .o_valid (w_even_vld),
        .o_hash  (w_even_hash)
    );

    sipeg_lane u_odd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_nonce ({i_edge_index, 1'b1}),
        .i_key   (w_key),
        .o_valid (w_odd_vld),
        .o_hash  (w_odd_hash)
    );

    // Mask, shift and register the nodes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_even_vld;
        end
        r_even <= {w_even_hash[L_IW-1:0] & L_MASK, 1'b0};
        r_odd  <= {w_odd_hash[L_IW-1:0] & L_MASK, 1'b1};
    end

    assign o_valid     = r_out_vld;
    assign o_even_node = r_even;
    assign o_odd_node  = r_odd;

    // Lanes run in lock step
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_even_vld == w_odd_vld)
        else $error("edge generator: lanes out of step");

    a_edge_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##14 o_valid)
        else $error("edge generator: result word missing");

    a_node_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_odd_node[0] && !o_even_node[0]))
        else $error("edge generator: node parity wrong");

    a_nonce_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> $past(L_NW == L_IW + 1))
        else $error("edge generator: nonce width mismatch");

endmodule
`default_nettype wire

[src/sipeg_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sipeg_lane
// One SipHash-2-4 pipeline: a load stage and twelve half-round stages.
// Takes one nonce per cycle; the hash is folded from the last stage's state.
// ============================================================================
module sipeg_lane (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  wire [sipeg_pkg::C_NONCE_W-1:0]       i_nonce,
    input  sipeg_pkg::t_sip_state                i_key,
    output logic                                 o_valid,
    output logic [sipeg_pkg::C_WORD_W-1:0]       o_hash
);

    localparam int L_N  = sipeg_pkg::C_HALF_ROUNDS;
    localparam int L_CH = sipeg_pkg::C_COMP_HALVES;
    localparam int L_WW = sipeg_pkg::C_WORD_W;

    sipeg_pkg::t_sip_state                  r_v   [0:L_N];
    logic                                   r_vld [0:L_N];
    logic [sipeg_pkg::C_NONCE_W-1:0]        r_nonce [0:L_CH];
    sipeg_pkg::t_sip_state                  n_load;

    // Load key words and mix the nonce into v3
    always_comb begin
        n_load   = i_key;
        n_load.d = i_key.d ^ L_WW'(i_nonce);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_v[0]     <= n_load;
        r_nonce[0] <= i_nonce;
    end

    // Carry the nonce until the end of compression
    for (genvar k = 0; k < L_CH; k++) begin : g_nonce
        always_ff @(posedge i_clk) begin
            r_nonce[k+1] <= r_nonce[k];
        end
    end

    // Half-round stages, with the finalization tweak ahead of stage L_CH
    for (genvar g = 0; g < L_N; g++) begin : g_stage
        sipeg_pkg::t_sip_state n_in;

        always_comb begin
            n_in = r_v[g];
            if (g == L_CH) begin
                n_in.a = r_v[g].a ^ L_WW'(r_nonce[L_CH]);
                n_in.c = r_v[g].c ^ sipeg_pkg::C_FINAL_XOR;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            if ((g % 2) == 0) begin
                r_v[g+1] <= sipeg_pkg::half_a(n_in);
            end else begin
                r_v[g+1] <= sipeg_pkg::half_b(n_in);
            end
        end
    end

    // Fold the final state
    assign o_valid = r_vld[L_N];
    assign o_hash  = r_v[L_N].a ^ r_v[L_N].b ^ r_v[L_N].c ^ r_v[L_N].d;

    // A word entering leaves after exactly the pipeline depth
    a_lane_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##13 o_valid)
        else $error("sipeg_lane: word lost in pipeline");

    a_lane_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, 13)) |-> $past(i_valid, 13))
        else $error("sipeg_lane: word appeared without entry");

endmodule
`default_nettype wire

[tb/tb_siphash_edge_generator_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_siphash_edge_generator_unit
// Self-checking bench for the edge generator (SipHash-2-4). Edge index words
// go in through the start/busy handshake while an independent SipHash model
// predicts both endpoints. Each node strobe is checked field by field
// against the oldest prediction. Keys change over the APB port between
// phases of idle-free, sparse and busy traffic, and each write is read back.
// ============================================================================
module tb_siphash_edge_generator_unit;

    // Package constants used by the bench
    localparam int C_EDGE_BITS = sipeg_pkg::C_EDGE_BITS;
    localparam int C_IN_W      = sipeg_pkg::C_IN_W;
    localparam int C_OUT_W     = sipeg_pkg::C_OUT_W;
    localparam int C_WORD_W    = sipeg_pkg::C_WORD_W;
    localparam int C_DATA_W    = sipeg_pkg::C_DATA_W;
    localparam int C_ADDR_W    = sipeg_pkg::C_ADDR_W;
    localparam logic [1:0] C_REG_KEY0 = sipeg_pkg::C_REG_KEY0;
    localparam logic [1:0] C_REG_KEY1 = sipeg_pkg::C_REG_KEY1;
    localparam logic [1:0] C_REG_KEY2 = sipeg_pkg::C_REG_KEY2;
    localparam logic [1:0] C_REG_KEY3 = sipeg_pkg::C_REG_KEY3;
    localparam logic [C_WORD_W-1:0] C_FINAL_XOR = sipeg_pkg::C_FINAL_XOR;

    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 7;
    localparam int PIPE_LATENCY = 14;
    localparam int SETTLE_WAIT  = 2 * PIPE_LATENCY;
    localparam int HANG_LIMIT   = 2000;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_EDGES  = 239;
    localparam int MAX_REPORTS  = 10;
    localparam logic [C_IN_W-1:0] EDGE_MAX = '1;

    // One predicted endpoint pair, tagged with its edge for messages
    typedef struct packed {
        logic [C_IN_W-1:0]  edge_idx;
        logic [C_OUT_W-1:0] even_node;
        logic [C_OUT_W-1:0] odd_node;
    } t_node_pair;

    // ------------------------------------------------------------------------
    // Endpoint scoreboard: own copy of the keys, SipHash predictor, and the
    // queue of endpoint pairs still owed by the block.
    // ------------------------------------------------------------------------
    class t_edge_node_scoreboard;
        logic [C_WORD_W-1:0] key_reg [4];
        t_node_pair          owed_nodes [$];
        int                  errors;

        function new();
            foreach (key_reg[i]) key_reg[i] = '0;
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
        endfunction

        function void set_key(int idx, logic [C_WORD_W-1:0] value);
            key_reg[idx] = value;
        endfunction

        function void check_key(int idx, logic [C_WORD_W-1:0] got);
            if (got !== key_reg[idx])
                flag($sformatf("key %0d readback exp %h got %h",
                               idx, key_reg[idx], got));
        endfunction

        function logic [C_WORD_W-1:0] rotl(logic [C_WORD_W-1:0] x, int unsigned r);
            return (x << r) | (x >> (C_WORD_W - r));
        endfunction

        function void mix_round(inout logic [C_WORD_W-1:0] a, b, c, d);
            a = a + b;  c = c + d;
            b = rotl(b, 13);  d = rotl(d, 16);
            b = b ^ a;  d = d ^ c;
            a = rotl(a, 32);
            c = c + b;  a = a + d;
            b = rotl(b, 17);  d = rotl(d, 21);
            b = b ^ c;  d = d ^ a;
            c = rotl(c, 32);
        endfunction

        // Two compression rounds, then four finalization rounds
        function logic [C_WORD_W-1:0] sip24(logic [C_WORD_W-1:0] nonce);
            logic [C_WORD_W-1:0] a, b, c, d;
            a = key_reg[0];
            b = key_reg[1];
            c = key_reg[2];
            d = key_reg[3] ^ nonce;
            repeat (2) mix_round(a, b, c, d);
            a = a ^ nonce;
            c = c ^ C_FINAL_XOR;
            repeat (4) mix_round(a, b, c, d);
            return a ^ b ^ c ^ d;
        endfunction

        // Mask to the graph size, shift left, cut to the node width
        function logic [C_OUT_W-1:0] to_node(logic [C_WORD_W-1:0] h, logic low_bit);
            logic [C_WORD_W-1:0] mask;
            logic [C_WORD_W-1:0] node;
            mask = (64'd1 << C_EDGE_BITS) - 64'd1;
            node = ((h & mask) << 1) | {63'd0, low_bit};
            return node[C_OUT_W-1:0];
        endfunction

        function void note_edge(logic [C_IN_W-1:0] e);
            t_node_pair p;
            logic [C_WORD_W-1:0] nonce;
            nonce       = {{(C_WORD_W-C_IN_W-1){1'b0}}, e, 1'b0};
            p.edge_idx  = e;
            p.even_node = to_node(sip24(nonce), 1'b0);
            p.odd_node  = to_node(sip24(nonce | 64'd1), 1'b1);
            owed_nodes.push_back(p);
        endfunction

        function void check_nodes(logic [C_OUT_W-1:0] even_got,
                                  logic [C_OUT_W-1:0] odd_got);
            t_node_pair p;
            if (owed_nodes.size() == 0) begin
                flag($sformatf("node word %h/%h with no edge pending", even_got, odd_got));
                return;
            end
            p = owed_nodes.pop_front();
            if (even_got !== p.even_node)
                flag($sformatf("edge %0d even_node exp %h got %h",
                               p.edge_idx, p.even_node, even_got));
            if (odd_got !== p.odd_node)
                flag($sformatf("edge %0d odd_node exp %h got %h",
                               p.edge_idx, p.odd_node, odd_got));
        endfunction

        function int pending();
            return owed_nodes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [C_IN_W-1:0]    i_edge_index;
    logic                 o_valid;
    logic [C_OUT_W-1:0]   o_even_node;
    logic [C_OUT_W-1:0]   o_odd_node;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [C_ADDR_W-1:0]  paddr;
    logic [C_DATA_W-1:0]  pwdata;
    logic [C_DATA_W-1:0]  prdata;
    logic                 pready;

    t_edge_node_scoreboard sb;
    int                   hang_cnt;
    logic [C_IN_W-1:0]    run_edge;
    int                   run_left;

    siphash_edge_generator_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_edge_index (i_edge_index),
        .o_valid      (o_valid),
        .o_even_node  (o_even_node),
        .o_odd_node   (o_odd_node),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Free-running clock, 20 ns period
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Note accepted edge words and check node words at each rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_nodes(o_even_node, o_odd_node);
            if (start && !busy) sb.note_edge(i_edge_index);
        end
    end

    // Abort when nothing moves on any port for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pready)) begin
            hang_cnt <= 0;
        end else begin
            hang_cnt <= hang_cnt + 1;
        end
        if (hang_cnt >= HANG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: all inputs change on the falling edge
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [1:0] idx, input logic [C_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_key(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(input logic [1:0] idx);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 3'b000};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.check_key(idx, prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Idle with the given odds, then hold the edge word until it is taken
    task automatic send_edge(input logic [C_IN_W-1:0] e, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start        = 1'b1;
        i_edge_index = e;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop start, wait for every owed node word, then let the pipe settle
    task automatic drain();
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly random edges, with runs of consecutive indexes as in graph
    // generation and an occasional extreme or one-hot index
    function automatic logic [C_IN_W-1:0] next_edge();
        int r;
        if (run_left > 0) begin
            run_left--;
            run_edge = run_edge + 1'b1;
            return run_edge;
        end
        r = $urandom_range(99);
        if (r < 5)  return ($urandom_range(1) != 0) ? EDGE_MAX : '0;
        if (r < 10) return C_IN_W'(1) << $urandom_range(C_IN_W-1);
        if (r < 40) begin
            run_edge = C_IN_W'($urandom);
            run_left = $urandom_range(31, 4);
            return run_edge;
        end
        return C_IN_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [C_IN_W-1:0]   directed_edges [16];
        logic [C_WORD_W-1:0] phase_key [4];
        int                  idle_pct;

        sb           = new();
        hang_cnt     = 0;
        run_edge     = '0;
        run_left     = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_edge_index = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        directed_edges = '{15'h0000, 15'h7fff, 15'h0001, 15'h4000,
                           15'h5555, 15'h2aaa, 15'h0002, 15'h7ffe,
                           15'h00ff, 15'h7f00, 15'h0003, 15'h1234,
                           15'h0f0f, 15'h70f0, 15'h3fff, 15'h0000};

        // Hold reset, then run directed edges under the all-zero reset keys
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        apb_read_check(C_REG_KEY0);
        apb_read_check(C_REG_KEY1);
        apb_read_check(C_REG_KEY2);
        apb_read_check(C_REG_KEY3);
        foreach (directed_edges[i]) send_edge(directed_edges[i], 0);
        drain();

        // Each phase: load new keys, read them back, then random traffic
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: phase_key = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                                 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff};
                2: phase_key = '{64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                                 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001};
                4: phase_key = '{64'h0000_0000_0000_0000, 64'haaaa_aaaa_aaaa_aaaa,
                                 64'hffff_ffff_ffff_ffff, 64'h5555_5555_5555_5555};
                default: begin
                    foreach (phase_key[k]) phase_key[k] = {$urandom, $urandom};
                end
            endcase
            apb_write(C_REG_KEY0, phase_key[0]);
            apb_write(C_REG_KEY1, phase_key[1]);
            apb_write(C_REG_KEY2, phase_key[2]);
            apb_write(C_REG_KEY3, phase_key[3]);
            apb_read_check(C_REG_KEY0);
            apb_read_check(C_REG_KEY1);
            apb_read_check(C_REG_KEY2);
            apb_read_check(C_REG_KEY3);

            // Rotate sender behavior: no gaps, mostly idle, lightly idle
            case (ph % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 73;
                default: idle_pct = 17;
            endcase
            run_left = 0;
            repeat (PHASE_EDGES) send_edge(next_edge(), idle_pct);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
src/sipeg_pkg.sv
src/sipeg_lane.sv
src/siphash_edge_generator_unit.sv
tb/tb_siphash_edge_generator_unit.sv
